// File: rtl/core/sobc_pkg.sv
// Shared constants and helpers for the sphere against oriented box contact core
`default_nettype none
package sobc_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ONE_Q14 = 16384;
  localparam int NREG = 5;
  typedef enum logic [2:0] {
    REG_RADIUS = 3'd0,
    REG_HX     = 3'd1,
    REG_HY     = 3'd2,
    REG_HZ     = 3'd3,
    REG_NEAR   = 3'd4
  } reg_idx_t;

  // round half up from Q14 products: add half, arithmetic shift
  function automatic logic signed [63:0] rnd14(input logic signed [63:0] x);
    rnd14 = (x + 64'sd8192) >>> 14;
  endfunction

  function automatic logic signed [63:0] abs64(input logic signed [63:0] x);
    abs64 = x[63] ? -x : x;
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/sobc_sqrt.sv
// Pipelined floor square root, one result bit per stage
`default_nettype none
module sobc_sqrt #(
  parameter int W = 64,
  parameter int TW = 8
) (
  input  wire logic            clk,
  input  wire logic [W-1:0]    rad,
  input  wire logic [TW-1:0]   tag_in,
  output logic [W/2-1:0]       root,
  output logic [TW-1:0]        tag_out
);
  localparam int N = W / 2;
  logic [W-1:0]   rem [0:N];
  logic [N-1:0]   res [0:N];
  logic [TW-1:0]  tag [0:N];

  assign rem[0] = rad;
  assign res[0] = '0;
  assign tag[0] = tag_in;

  for (genvar s = 0; s < N; s++) begin : g_st
    logic [W+1:0] trial;
    logic [W+1:0] rem_sh;
    always_comb begin
      // candidate bit b = N-1-s: test res * 2^(b+1) + 4^b against the remainder
      trial  = ({{(W+2-N){1'b0}}, res[s]} << (N-s))
             | ({{(W+1){1'b0}}, 1'b1} << (2*(N-1-s)));
      rem_sh = {2'b00, rem[s]};
    end
    always_ff @(posedge clk) begin
      if (rem_sh >= trial) begin
        rem[s+1] <= W'(rem_sh - trial);
        res[s+1] <= res[s] | (N'(1) << (N-1-s));
      end else begin
        rem[s+1] <= rem[s];
        res[s+1] <= res[s];
      end
      tag[s+1]  <= tag[s];
    end
  end

  assign root = res[N];
  assign tag_out = tag[N];
endmodule
`default_nettype wire

// File: rtl/core/sphere_oriented_box_contact_core.sv
// Top level of the sphere against oriented box contact core
`default_nettype none
// Pipeline: 6 front stages, 32 square root stages, 1 normal-setup stage,
// 16 divide stages and 3 back stages; done strobes once per accepted start.
// Throughput: one transaction per cycle; busy is held low and the receiver
// cannot stall, so the pipeline never stalls.
// The outside-normal divide is a pipelined restoring divider (16 stages).
// Reset (rst, synchronous) clears valid bits and restores register defaults.
module sphere_oriented_box_contact_core #(
  parameter int FRAC_BITS = sobc_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] sphere_x,
  input  wire logic signed [31:0] sphere_y,
  input  wire logic signed [31:0] sphere_z,
  input  wire logic signed [31:0] box_x,
  input  wire logic signed [31:0] box_y,
  input  wire logic signed [31:0] box_z,
  input  wire logic signed [15:0] rot_w,
  input  wire logic signed [15:0] rot_i,
  input  wire logic signed [15:0] rot_j,
  input  wire logic signed [15:0] rot_k,
  output logic                    done,
  output logic                    hit,
  output logic signed [15:0]      normal_x,
  output logic signed [15:0]      normal_y,
  output logic signed [15:0]      normal_z,
  output logic signed [31:0]      contact_x,
  output logic signed [31:0]      contact_y,
  output logic signed [31:0]      contact_z,
  output logic [30:0]             depth
);
  import sobc_pkg::*;

  // ---------------- configuration registers ----------------
  logic [30:0] sphere_radius, half_extent_x, half_extent_y, half_extent_z;
  logic [15:0] near_zero_limit;
  reg_idx_t    widx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius   <= 31'(64'd1 << FRAC_BITS);
      half_extent_x   <= 31'(64'd1 << FRAC_BITS);
      half_extent_y   <= 31'(64'd1 << FRAC_BITS);
      half_extent_z   <= 31'(64'd1 << FRAC_BITS);
      near_zero_limit <= 16'd1;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (widx)
        REG_RADIUS: sphere_radius   <= pwdata[30:0];
        REG_HX:     half_extent_x   <= pwdata[30:0];
        REG_HY:     half_extent_y   <= pwdata[30:0];
        REG_HZ:     half_extent_z   <= pwdata[30:0];
        REG_NEAR:   near_zero_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (widx)
        REG_RADIUS: prdata = {1'b0, sphere_radius};
        REG_HX:     prdata = {1'b0, half_extent_x};
        REG_HY:     prdata = {1'b0, half_extent_y};
        REG_HZ:     prdata = {1'b0, half_extent_z};
        REG_NEAR:   prdata = {16'd0, near_zero_limit};
        default:    prdata = '0;
      endcase
    end
  end

  logic signed [63:0] rr, hx, hy, hz;
  assign rr = 64'(sphere_radius);
  assign hx = 64'(half_extent_x);
  assign hy = 64'(half_extent_y);
  assign hz = 64'(half_extent_z);

  // ---------------- S1: offset, quaternion products ----------------
  logic        v1;
  logic signed [32:0] d1 [3];
  logic signed [31:0] b1 [3];
  logic signed [31:0] pii, pjj, pkk, pij, pik, pjk, pwi, pwj, pwk;
  always_ff @(posedge clk) begin
    v1 <= rst ? 1'b0 : (start && !busy);
    d1[0] <= 33'(sphere_x) - 33'(box_x);
    d1[1] <= 33'(sphere_y) - 33'(box_y);
    d1[2] <= 33'(sphere_z) - 33'(box_z);
    b1[0] <= box_x; b1[1] <= box_y; b1[2] <= box_z;
    pii <= rot_i * rot_i; pjj <= rot_j * rot_j; pkk <= rot_k * rot_k;
    pij <= rot_i * rot_j; pik <= rot_i * rot_k; pjk <= rot_j * rot_k;
    pwi <= rot_w * rot_i; pwj <= rot_w * rot_j; pwk <= rot_w * rot_k;
  end

  // ---------------- S2: rotation matrix in Q14 ----------------
  localparam logic signed [63:0] ONE28 = 64'sd1 <<< 28;
  logic        v2;
  logic signed [32:0] d2 [3];
  logic signed [31:0] b2 [3];
  logic signed [17:0] m2 [3][3];
  always_ff @(posedge clk) begin
    v2 <= rst ? 1'b0 : v1;
    d2 <= d1; b2 <= b1;
    m2[0][0] <= 18'(rnd14(ONE28 - 2 * (64'(pjj) + 64'(pkk))));
    m2[0][1] <= 18'(rnd14(2 * (64'(pij) - 64'(pwk))));
    m2[0][2] <= 18'(rnd14(2 * (64'(pik) + 64'(pwj))));
    m2[1][0] <= 18'(rnd14(2 * (64'(pij) + 64'(pwk))));
    m2[1][1] <= 18'(rnd14(ONE28 - 2 * (64'(pii) + 64'(pkk))));
    m2[1][2] <= 18'(rnd14(2 * (64'(pjk) - 64'(pwi))));
    m2[2][0] <= 18'(rnd14(2 * (64'(pik) - 64'(pwj))));
    m2[2][1] <= 18'(rnd14(2 * (64'(pjk) + 64'(pwi))));
    m2[2][2] <= 18'(rnd14(ONE28 - 2 * (64'(pii) + 64'(pjj))));
  end

  // ---------------- S3: matrix-vector products ----------------
  logic        v3;
  logic signed [31:0] b3 [3];
  logic signed [17:0] m3 [3][3];
  logic signed [51:0] pr3 [3][3];
  always_ff @(posedge clk) begin
    v3 <= rst ? 1'b0 : v2;
    b3 <= b2; m3 <= m2;
    for (int a = 0; a < 3; a++)
      for (int k = 0; k < 3; k++)
        pr3[a][k] <= 52'(m2[k][a] * d2[k]);
  end

  // ---------------- S4: box-space point, clamp ----------------
  logic        v4;
  logic signed [31:0] b4 [3];
  logic signed [17:0] m4 [3][3];
  logic signed [39:0] c4 [3];
  logic signed [39:0] cl4 [3];
  always_ff @(posedge clk) begin
    logic signed [63:0] cc;
    logic signed [63:0] hh;
    v4 <= rst ? 1'b0 : v3;
    b4 <= b3; m4 <= m3;
    for (int a = 0; a < 3; a++) begin
      cc = rnd14(64'(pr3[a][0]) + 64'(pr3[a][1]) + 64'(pr3[a][2]));
      hh = (a == 0) ? hx : (a == 1) ? hy : hz;
      c4[a] <= 40'(cc);
      cl4[a] <= (cc > hh) ? 40'(hh) : (cc < -hh) ? 40'(-hh) : 40'(cc);
    end
  end

  // ---------------- S5: offset squares ----------------
  // squares only matter when every axis gap is below the radius (< 2^31)
  logic        v5;
  logic signed [31:0] b5 [3];
  logic signed [17:0] m5 [3][3];
  logic signed [39:0] c5 [3], cl5 [3], dl5 [3];
  logic [2:0]  far5;
  logic [63:0] sq5 [3];
  logic [61:0] rsq5;
  always_ff @(posedge clk) begin
    logic signed [39:0] dd;
    logic [39:0]        ad;
    logic [61:0]        sqv;
    v5 <= rst ? 1'b0 : v4;
    b5 <= b4; m5 <= m4; c5 <= c4; cl5 <= cl4;
    rsq5 <= sphere_radius * sphere_radius;
    for (int a = 0; a < 3; a++) begin
      dd = c4[a] - cl4[a];
      ad = 40'(abs64(64'(dd)));
      sqv = ad[30:0] * ad[30:0];
      dl5[a] <= dd;
      far5[a] <= abs64(64'(dd)) >= rr;
      sq5[a] <= {2'b00, sqv};
    end
  end

  // ---------------- S6: squared distance, early reject ----------------
  typedef struct packed {
    logic               v;
    logic               hit;
    logic signed [31:0] b0, b1, b2;
    logic signed [17:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [39:0] c0, c1, c2, cl0, cl1, cl2, dl0, dl1, dl2;
    logic [30:0]        r;
    logic [15:0]        nzl;
  } item_t;
  localparam int IW = $bits(item_t);

  item_t i6;
  logic [63:0] dsq6;
  always_ff @(posedge clk) begin
    logic [63:0] s;
    s = sq5[0] + sq5[1] + sq5[2];
    dsq6 <= s;
    i6.v <= rst ? 1'b0 : v5;
    i6.hit <= (far5 == 3'b000) && (s < {2'b00, rsq5});
    {i6.b0, i6.b1, i6.b2} <= {b5[0], b5[1], b5[2]};
    {i6.m00, i6.m01, i6.m02} <= {m5[0][0], m5[0][1], m5[0][2]};
    {i6.m10, i6.m11, i6.m12} <= {m5[1][0], m5[1][1], m5[1][2]};
    {i6.m20, i6.m21, i6.m22} <= {m5[2][0], m5[2][1], m5[2][2]};
    {i6.c0, i6.c1, i6.c2} <= {c5[0], c5[1], c5[2]};
    {i6.cl0, i6.cl1, i6.cl2} <= {cl5[0], cl5[1], cl5[2]};
    {i6.dl0, i6.dl1, i6.dl2} <= {dl5[0], dl5[1], dl5[2]};
    i6.r <= sphere_radius;
    i6.nzl <= near_zero_limit;
  end

  // ---------------- square root pipeline ----------------
  logic [31:0] dist7;
  logic [IW-1:0] tag7;
  item_t i7;
  sobc_sqrt #(.W(64), .TW(IW)) u_sqrt (
    .clk(clk), .rad(dsq6), .tag_in(i6), .root(dist7), .tag_out(tag7)
  );
  assign i7 = item_t'(tag7);

  // valid travels outside the tag too so reset clears it
  logic [31:0] vsh;
  always_ff @(posedge clk) begin
    if (rst) vsh <= '0;
    else     vsh <= {vsh[30:0], i6.v};
  end

  // ---------------- S8: normal setup ----------------
  // outside: divide |dl|*16384 + dist/2 by dist (pipelined)
  logic        v8, out8;
  item_t       i8;
  logic [31:0] dist8;
  logic [63:0] num8 [3];
  logic signed [17:0] nin8 [3];
  logic signed [63:0] dep8;
  always_ff @(posedge clk) begin
    logic signed [63:0] p0, p1, p2;
    logic               outside;
    logic [1:0]         ax;
    logic signed [17:0] nsel [3];
    v8 <= rst ? 1'b0 : (vsh[31] && i7.hit);
    i8 <= i7;
    dist8 <= dist7;
    outside = dist7 > 32'(i7.nzl);
    out8 <= outside;
    num8[0] <= (64'(abs64(64'(i7.dl0))) << 14) + 64'(dist7 >> 1);
    num8[1] <= (64'(abs64(64'(i7.dl1))) << 14) + 64'(dist7 >> 1);
    num8[2] <= (64'(abs64(64'(i7.dl2))) << 14) + 64'(dist7 >> 1);
    p0 = hx - abs64(64'(i7.c0));
    p1 = hy - abs64(64'(i7.c1));
    p2 = hz - abs64(64'(i7.c2));
    if (p0 < p1 && p0 < p2) ax = 2'd0;
    else if (p1 < p2)       ax = 2'd1;
    else                    ax = 2'd2;
    for (int a = 0; a < 3; a++) nsel[a] = '0;
    unique case (ax)
      2'd0: nsel[0] = i7.c0[39] ? -18'sd16384 : 18'sd16384;
      2'd1: nsel[1] = i7.c1[39] ? -18'sd16384 : 18'sd16384;
      default: nsel[2] = i7.c2[39] ? -18'sd16384 : 18'sd16384;
    endcase
    nin8 <= nsel;
    if (outside) dep8 <= 64'(i7.r) - 64'(dist7);
    else dep8 <= 64'(i7.r) + ((ax == 2'd0) ? p0 : (ax == 2'd1) ? p1 : p2);
  end

  // ---------------- divider: 16 restoring stages ----------------
  // quotients of 2^16 or more are flagged up front; 16 bits cover the rest
  localparam int QB = 16;
  logic        vq [0:QB];
  item_t       iq [0:QB];
  logic        oq [0:QB];
  logic [31:0] dq [0:QB];
  logic [63:0] rq [0:QB][3];
  logic [QB-1:0] qq [0:QB][3];
  logic [2:0]  ovq [0:QB];
  logic signed [17:0] nq [0:QB][3];
  logic signed [63:0] eq [0:QB];

  always_comb begin
    vq[0] = v8; iq[0] = i8; oq[0] = out8; dq[0] = dist8; eq[0] = dep8;
    for (int a = 0; a < 3; a++) begin
      rq[0][a] = num8[a];
      qq[0][a] = '0;
      nq[0][a] = nin8[a];
      // quotient at least 2^16 saturates anyway
      ovq[0][a] = (num8[a] >> 16) >= 64'(dist8);
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    always_ff @(posedge clk) begin
      logic [63:0] t;
      vq[s+1] <= rst ? 1'b0 : vq[s];
      iq[s+1] <= iq[s]; oq[s+1] <= oq[s]; dq[s+1] <= dq[s];
      ovq[s+1] <= ovq[s]; nq[s+1] <= nq[s]; eq[s+1] <= eq[s];
      for (int a = 0; a < 3; a++) begin
        t = 64'(dq[s]) << (QB-1-s);
        if (!ovq[s][a] && rq[s][a] >= t) begin
          rq[s+1][a] <= rq[s][a] - t;
          qq[s+1][a] <= qq[s][a] | (QB'(1) << (QB-1-s));
        end else begin
          rq[s+1][a] <= rq[s][a];
          qq[s+1][a] <= qq[s][a];
        end
      end
    end
  end

  // ---------------- B1: local normal ----------------
  logic        vb1;
  item_t       ib1;
  logic signed [17:0] nl1 [3];
  logic signed [63:0] dep1;
  always_ff @(posedge clk) begin
    logic [16:0] mag;
    logic signed [39:0] dsel;
    vb1 <= rst ? 1'b0 : vq[QB];
    ib1 <= iq[QB];
    dep1 <= eq[QB];
    for (int a = 0; a < 3; a++) begin
      dsel = (a == 0) ? iq[QB].dl0 : (a == 1) ? iq[QB].dl1 : iq[QB].dl2;
      mag = (ovq[QB][a] || qq[QB][a] > QB'(ONE_Q14)) ? 17'(ONE_Q14)
                                                     : 17'(qq[QB][a]);
      if (oq[QB]) nl1[a] <= dsel[39] ? -18'(mag) : 18'(mag);
      else        nl1[a] <= nq[QB][a];
    end
  end

  // ---------------- B2: world products ----------------
  logic        vb2;
  logic signed [31:0] bb2 [3];
  logic signed [35:0] np2 [3][3];
  logic signed [57:0] pp2 [3][3];
  logic [30:0] dep2;
  always_ff @(posedge clk) begin
    logic signed [17:0] mr [3][3];
    logic signed [39:0] cl [3];
    mr[0][0] = ib1.m00; mr[0][1] = ib1.m01; mr[0][2] = ib1.m02;
    mr[1][0] = ib1.m10; mr[1][1] = ib1.m11; mr[1][2] = ib1.m12;
    mr[2][0] = ib1.m20; mr[2][1] = ib1.m21; mr[2][2] = ib1.m22;
    cl[0] = ib1.cl0; cl[1] = ib1.cl1; cl[2] = ib1.cl2;
    vb2 <= rst ? 1'b0 : vb1;
    bb2[0] <= ib1.b0; bb2[1] <= ib1.b1; bb2[2] <= ib1.b2;
    dep2 <= dep1[63] ? 31'd0 : (dep1 > 64'sh7FFFFFFF) ? 31'h7FFFFFFF : 31'(dep1);
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) begin
        np2[a][b] <= 36'(mr[a][b] * nl1[b]);
        pp2[a][b] <= 58'(mr[a][b] * cl[b]);
      end
  end

  // every item, hit or not, strobes at the same point: align the raw
  // valid from the sqrt output with the back end through vtail
  logic [18:0] vtail;
  always_ff @(posedge clk) begin
    if (rst) vtail <= '0;
    else     vtail <= {vtail[17:0], vsh[31]};
  end

  // ---------------- B3: sums, saturation, output register ----------------
  always_ff @(posedge clk) begin
    logic signed [63:0] n, p;
    logic signed [15:0] nn [3];
    logic signed [31:0] pc [3];
    for (int a = 0; a < 3; a++) begin
      n = rnd14(64'(np2[a][0]) + 64'(np2[a][1]) + 64'(np2[a][2]));
      if (n > 64'sd16384) n = 64'sd16384;
      else if (n < -64'sd16384) n = -64'sd16384;
      nn[a] = 16'(-n);
      p = rnd14(64'(pp2[a][0]) + 64'(pp2[a][1]) + 64'(pp2[a][2])) + 64'(bb2[a]);
      if (p > 64'sh7FFFFFFF) pc[a] = 32'sh7FFFFFFF;
      else if (p < -64'sh80000000) pc[a] = 32'sh80000000;
      else pc[a] = 32'(p);
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vtail[18];
    end
    hit       <= vb2;
    normal_x  <= vb2 ? nn[0] : '0;
    normal_y  <= vb2 ? nn[1] : '0;
    normal_z  <= vb2 ? nn[2] : '0;
    contact_x <= vb2 ? pc[0] : '0;
    contact_y <= vb2 ? pc[1] : '0;
    contact_z <= vb2 ? pc[2] : '0;
    depth     <= vb2 ? dep2 : '0;
  end
endmodule
`default_nettype wire
